FILE: rtl/mbc1_pkg.sv
// Shared types and address-map constants for the MBC1 bank mapper.
`default_nettype none

package mbc1_pkg;

  // Result target codes
  typedef enum logic [2:0] {
    TGT_ROM       = 3'd0,
    TGT_RAM_DONE  = 3'd1,
    TGT_RAM_OFF   = 3'd2,
    TGT_RAM_RANGE = 3'd3,
    TGT_CONTROL   = 3'd4,
    TGT_PASS      = 3'd5
  } target_t;

  // Control-write regions, selected by address[14:13] below 0x8000
  typedef enum logic [1:0] {
    CTL_RAM_EN    = 2'd0,   // 0x0000-0x1FFF
    CTL_ROM_BANK  = 2'd1,   // 0x2000-0x3FFF
    CTL_UPPER_SEL = 2'd2,   // 0x4000-0x5FFF
    CTL_MODE      = 2'd3    // 0x6000-0x7FFF
  } ctl_reg_t;

  localparam logic [15:0] ROM0_LAST    = 16'h3FFF;
  localparam logic [15:0] ROMX_LAST    = 16'h7FFF;
  localparam logic [15:0] RAM_BASE     = 16'hA000;
  localparam logic [15:0] RAM_LAST     = 16'hBFFF;
  localparam logic [3:0]  RAM_EN_KEY   = 4'hA;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ROM_ADDR_W = 21;
  localparam int unsigned RAM_ADDR_W = 15;
  localparam int unsigned SIZE_W     = 16;

endpackage

`default_nettype wire

FILE: rtl/mbc1_req_if.sv
// Bus access request channel: valid/ready plus one CPU access.
`default_nettype none

interface mbc1_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbc1_rsp_if.sv
// Translation result channel: valid/ready plus one mapped access result.
`default_nettype none

interface mbc1_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [20:0] rom_address;
  logic [14:0] ram_address;
  logic [7:0]  read_data;

  modport source (output valid, output target, output rom_address, output ram_address,
                  output read_data, input ready);
  modport sink   (input valid, input target, input rom_address, input ram_address,
                  input read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbc1_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module mbc1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mbc1_bank_mapper_core.sv
// MBC1 bank mapper top level: bus decode, banking registers and cartridge RAM.
//
// Usage:
//  - in_bus carries one CPU access per transfer (op, address, write_data).
//    A transfer happens on a rising clk edge with valid and ready high.
//  - out_bus returns exactly one result per access: target code, mapped
//    ROM address, mapped RAM address and RAM read data.
//  - cfg_valid/cfg_data write ram_size_bytes (fitted RAM, 0 = none);
//    cfg_ready is always high. Write it only while the block is idle.
//  - Latency: the result is presented the cycle after the access transfer.
//  - Throughput: one access per cycle unless stalled. The single result stage
//    is backed by the RAM's registered read port; the cartridge RAM is accessed
//    once per item (read or write, never both), so no forwarding is needed.
//  - Banking-register writes take effect for the very next access.
//  - Stall: while out_bus.ready is low the result stage and RAM read data
//    hold, and in_bus.ready drops only when that stage is full.
//  - Reset (rst_n low, synchronous): RAM disabled, ROM bank 1, upper
//    select 0, ROM banking mode, ram_size_bytes 0, pipeline empty.
//    The RAM contents are not cleared; unwritten bytes read as garbage.
`default_nettype none

module mbc1_bank_mapper_core #(
  parameter int unsigned RAM_BYTES = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mbc1_req_if.sink         in_bus,
  mbc1_rsp_if.source       out_bus,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = $clog2(RAM_BYTES);
  localparam logic [mbc1_pkg::SIZE_W:0] RAM_LIMIT = (mbc1_pkg::SIZE_W + 1)'(RAM_BYTES);

  // Banking state
  logic                          ram_enabled_r, ram_enabled_nxt;
  logic [4:0]                    rom_bank_low_r, rom_bank_low_nxt;
  logic [1:0]                    upper_sel_r, upper_sel_nxt;
  logic                          mode_r, mode_nxt;
  logic [mbc1_pkg::SIZE_W-1:0]   ram_size_r;

  // Result stage
  logic                            s1_valid_r;
  mbc1_pkg::target_t               tgt_r, tgt_nxt;
  logic [mbc1_pkg::ROM_ADDR_W-1:0] rom_addr_r, rom_addr_nxt;
  logic [mbc1_pkg::RAM_ADDR_W-1:0] ram_addr_r, ram_addr_nxt;
  logic                            rd_sel_r, rd_sel_nxt;

  logic                            in_xfer;
  logic                            ram_we, ram_re;
  logic [mbc1_pkg::RAM_ADDR_W-1:0] ram_map;
  logic [6:0]                      romx_bank;
  logic                            ram_in_range;
  logic [mbc1_pkg::DATA_W-1:0]     ram_rdata;

  assign cfg_ready    = 1'b1;
  assign in_bus.ready = !s1_valid_r || out_bus.ready;
  assign in_xfer      = in_bus.valid && in_bus.ready;

  // Mode 0: upper select feeds ROM bank bits 6:5; mode 1: it picks the RAM bank.
  assign romx_bank = {(mode_r ? 2'b00 : upper_sel_r), rom_bank_low_r};
  assign ram_map   = {(mode_r ? upper_sel_r : 2'b00), in_bus.address[12:0]};
  assign ram_in_range = ({1'b0, ram_map} < ram_size_r) &&
                        ({2'b00, ram_map} < RAM_LIMIT);

  always_comb begin
    ram_enabled_nxt  = ram_enabled_r;
    rom_bank_low_nxt = rom_bank_low_r;
    upper_sel_nxt    = upper_sel_r;
    mode_nxt         = mode_r;
    tgt_nxt          = mbc1_pkg::TGT_PASS;
    rom_addr_nxt     = '0;
    ram_addr_nxt     = '0;
    rd_sel_nxt       = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    if (in_bus.op && in_bus.address <= mbc1_pkg::ROMX_LAST) begin
      // Writes into ROM space program the banking registers
      tgt_nxt = mbc1_pkg::TGT_CONTROL;
      case (mbc1_pkg::ctl_reg_t'(in_bus.address[14:13]))
        mbc1_pkg::CTL_RAM_EN: begin
          ram_enabled_nxt = (in_bus.write_data[3:0] == mbc1_pkg::RAM_EN_KEY);
        end
        mbc1_pkg::CTL_ROM_BANK: begin
          // zero byte maps to bank 1 before the 5-bit mask
          rom_bank_low_nxt = (in_bus.write_data == '0) ? 5'd1 : in_bus.write_data[4:0];
        end
        mbc1_pkg::CTL_UPPER_SEL: begin
          upper_sel_nxt = in_bus.write_data[1:0];
        end
        mbc1_pkg::CTL_MODE: begin
          mode_nxt = in_bus.write_data[0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end else if (in_bus.address <= mbc1_pkg::ROM0_LAST) begin
      tgt_nxt      = mbc1_pkg::TGT_ROM;
      rom_addr_nxt = {7'd0, in_bus.address[13:0]};
    end else if (in_bus.address <= mbc1_pkg::ROMX_LAST) begin
      tgt_nxt      = mbc1_pkg::TGT_ROM;
      rom_addr_nxt = {romx_bank, in_bus.address[13:0]};
    end else if (in_bus.address >= mbc1_pkg::RAM_BASE &&
                 in_bus.address <= mbc1_pkg::RAM_LAST) begin
      if (!ram_enabled_r) begin
        tgt_nxt = mbc1_pkg::TGT_RAM_OFF;
      end else if (!ram_in_range) begin
        tgt_nxt      = mbc1_pkg::TGT_RAM_RANGE;
        ram_addr_nxt = ram_map;
      end else begin
        tgt_nxt      = mbc1_pkg::TGT_RAM_DONE;
        ram_addr_nxt = ram_map;
        rd_sel_nxt   = !in_bus.op;
        ram_we       = in_xfer && in_bus.op;
        ram_re       = in_xfer && !in_bus.op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enabled_r  <= 1'b0;
      rom_bank_low_r <= 5'd1;
      upper_sel_r    <= 2'd0;
      mode_r         <= 1'b0;
      ram_size_r     <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ram_size_r <= cfg_data;
      end
      if (in_xfer) begin
        ram_enabled_r  <= ram_enabled_nxt;
        rom_bank_low_r <= rom_bank_low_nxt;
        upper_sel_r    <= upper_sel_nxt;
        mode_r         <= mode_nxt;
        s1_valid_r     <= 1'b1;
      end else if (out_bus.ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt_r      <= tgt_nxt;
      rom_addr_r <= rom_addr_nxt;
      ram_addr_r <= ram_addr_nxt;
      rd_sel_r   <= rd_sel_nxt;
    end
  end

  mbc1_ram #(
    .WIDTH (mbc1_pkg::DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_cart_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_map[AW-1:0]),
    .wdata (in_bus.write_data),
    .rdata (ram_rdata)
  );

  assign out_bus.valid       = s1_valid_r;
  assign out_bus.target      = tgt_r;
  assign out_bus.rom_address = rom_addr_r;
  assign out_bus.ram_address = ram_addr_r;
  assign out_bus.read_data   = rd_sel_r ? ram_rdata : '0;

  // Checks
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_bus.ready) |=>
      (s1_valid_r && $stable(tgt_r) && $stable(rom_addr_r) &&
       $stable(ram_addr_r) && $stable(rd_sel_r)))
    else $error("Stalled result changed or was dropped");

  a_rd_sel_is_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && rd_sel_r) |-> (tgt_r == mbc1_pkg::TGT_RAM_DONE))
    else $error("RAM read data selected for a non-RAM result");

  a_rdata_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && rd_sel_r && !out_bus.ready) |=> $stable(ram_rdata))
    else $error("RAM read data changed under a stalled result");

  a_ram_access_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || ram_re) |-> (ram_enabled_r && ram_in_range && in_xfer))
    else $error("RAM accessed while disabled, out of range or without transfer");

endmodule

`default_nettype wire
